@@ rtl/core/wlls_pkg.sv @@
package wlls_pkg;

   localparam int MaxThreadsDefault = 256;
   localparam int RingDepth = 256;
   localparam int RingAw = 8;
   localparam int IdW = 8;
   localparam int RndW = 20;
   localparam int WeightW = 4;
   localparam int SumW = 6;
   localparam int CsrIdxW = 2;

   localparam logic [WeightW-1:0] HighWeightReset = 4'd9;
   localparam logic [WeightW-1:0] MiddleWeightReset = 4'd6;
   localparam logic [WeightW-1:0] LowWeightReset = 4'd4;

   localparam logic [CsrIdxW-1:0] CsrHighWeight = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMiddleWeight = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrLowWeight = 2'd2;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_PREEMPT = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BAD_LEVEL = 3'd1,
      ST_FULL = 3'd2,
      ST_NOT_READY = 3'd3,
      ST_NO_DISPATCH = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic read;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic need_mod;
      logic mod_done;
   } stat_type;

endpackage

@@ rtl/core/weighted_level_lottery_scheduler_top.sv @@
// Three-level weighted lottery scheduler.
// Command channel: drive req_op, req_prio_level and req_random_value with
// start; the command is taken at a clock edge where start is high and busy
// is low. busy stays high until the response has been issued.
// Response channel: rsp_valid is high for exactly one cycle with
// rsp_status, rsp_thread_id and rsp_chosen_level. The receiver cannot
// stall; the response must be captured in that cycle.
// Sequence: a dispatch with a nonzero ticket total runs the bit-serial
// modulo unit in S_MOD, then one ring read in S_READ, then the update in
// S_RESP, which registers the response; other commands pass S_MOD
// without modulo steps.
// busy is low in the response cycle; one command is in flight at a time.
// Weights are written through csr_write/csr_index/csr_wdata; the user
// must write them only while idle, as the block does not enforce it.
// Reset (synchronous, active high) empties all rings, clears the id
// counter, the ticket mask and the dispatch record, and restores the
// weights to 9, 6 and 4. Ring contents are not cleared.
module weighted_level_lottery_scheduler_top #(
   parameter int MaxThreads = wlls_pkg::MaxThreadsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_op,
   input  logic [1:0] req_prio_level,
   input  logic [wlls_pkg::RndW-1:0] req_random_value,
   input  logic csr_write,
   input  logic [wlls_pkg::CsrIdxW-1:0] csr_index,
   input  logic [wlls_pkg::WeightW-1:0] csr_wdata,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [wlls_pkg::IdW-1:0] rsp_thread_id,
   output logic [1:0] rsp_chosen_level
);
   import wlls_pkg::*;

   cmd_type cmd;
   stat_type stat;

   wlls_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   wlls_dp #(.MaxThreads(MaxThreads)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_op(req_op), .req_prio_level(req_prio_level),
      .req_random_value(req_random_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_thread_id(rsp_thread_id), .rsp_chosen_level(rsp_chosen_level)
   );
endmodule

@@ rtl/core/wlls_ctrl.sv @@
module wlls_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  wlls_pkg::stat_type stat,
   output wlls_pkg::cmd_type cmd
);
   import wlls_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_MOD;
         S_MOD: if (!stat.need_mod || stat.mod_done) state_in = S_READ;
         S_READ: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: cmd.load = start;
         S_MOD: cmd.mod_step = 1'b1;
         S_READ: cmd.read = 1'b1;
         S_RESP: cmd.respond = 1'b1;
         default: ;
      endcase
   end
endmodule

@@ rtl/core/wlls_dp.sv @@
module wlls_dp #(
   parameter int MaxThreads = wlls_pkg::MaxThreadsDefault
) (
   input  logic clock,
   input  logic reset,
   input  wlls_pkg::cmd_type cmd,
   output wlls_pkg::stat_type stat,
   input  logic [1:0] req_op,
   input  logic [1:0] req_prio_level,
   input  logic [wlls_pkg::RndW-1:0] req_random_value,
   input  logic csr_write,
   input  logic [wlls_pkg::CsrIdxW-1:0] csr_index,
   input  logic [wlls_pkg::WeightW-1:0] csr_wdata,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [wlls_pkg::IdW-1:0] rsp_thread_id,
   output logic [1:0] rsp_chosen_level
);
   import wlls_pkg::*;

   localparam int NidW = $clog2(MaxThreads);
   localparam logic [NidW-1:0] IdLimit = NidW'(MaxThreads - 1);
   localparam int StepW = $clog2(RndW + 1);

   logic [IdW-1:0] ring_mem [3][RingDepth];
   logic [IdW-1:0] rd_ff;
   logic [RingAw-1:0] head_ff [3];
   logic [RingAw:0] count_ff [3];
   logic [NidW-1:0] next_id_ff;
   logic [2:0] mask_ff;
   logic mask_valid_ff;
   logic [1:0] disp_ff;
   logic has_disp_ff;
   logic [WeightW-1:0] weight_ff [3];

   logic [1:0] op_ff;
   logic [1:0] lvl_ff;
   logic [RndW-1:0] rnd_ff;
   logic [SumW-1:0] rem_ff;
   logic [StepW-1:0] step_ff;
   logic [2:0] use_mask_ff;
   logic [SumW-1:0] sum_ff;

   logic [2:0] live_mask;
   logic [2:0] cur_mask;
   logic [SumW-1:0] cur_sum;
   logic [SumW:0] trial;
   logic [1:0] pick;
   logic [SumW-1:0] t0, t1;
   logic [1:0] err_level;

   assign live_mask = {count_ff[2] != '0, count_ff[1] != '0, count_ff[0] != '0};
   assign cur_mask = mask_valid_ff ? mask_ff : live_mask;
   assign cur_sum = (cur_mask[0] ? SumW'(weight_ff[0]) : '0)
      + (cur_mask[1] ? SumW'(weight_ff[1]) : '0)
      + (cur_mask[2] ? SumW'(weight_ff[2]) : '0);
   assign trial = {rem_ff, rnd_ff[RndW-1]};

   assign stat.need_mod = (op_ff == OP_DISPATCH) && (sum_ff != '0);
   assign stat.mod_done = (step_ff == StepW'(RndW - 1));

   always_comb begin
      t0 = sum_ff == '0 ? '0 : rem_ff;
      pick = 2'd3;
      t1 = t0;
      if (use_mask_ff[0] && t1 < SumW'(weight_ff[0])) pick = 2'd0;
      else begin
         if (use_mask_ff[0]) t1 = t1 - SumW'(weight_ff[0]);
         if (use_mask_ff[1] && t1 < SumW'(weight_ff[1])) pick = 2'd1;
         else begin
            if (use_mask_ff[1]) t1 = t1 - SumW'(weight_ff[1]);
            if (use_mask_ff[2] && t1 < SumW'(weight_ff[2])) pick = 2'd2;
         end
      end
      if (pick == 2'd3) begin
         priority if (use_mask_ff[0]) pick = 2'd0;
         else if (use_mask_ff[1]) pick = 2'd1;
         else if (use_mask_ff[2]) pick = 2'd2;
      end
   end

   assign err_level = (op_ff == OP_DISPATCH) ? pick : disp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[0] <= HighWeightReset;
         weight_ff[1] <= MiddleWeightReset;
         weight_ff[2] <= LowWeightReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrHighWeight: weight_ff[0] <= csr_wdata;
            CsrMiddleWeight: weight_ff[1] <= csr_wdata;
            CsrLowWeight: weight_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         lvl_ff <= req_prio_level;
         rnd_ff <= req_random_value;
         rem_ff <= '0;
         step_ff <= '0;
         use_mask_ff <= cur_mask;
         sum_ff <= cur_sum;
      end else if (cmd.mod_step && stat.need_mod) begin
         rnd_ff <= {rnd_ff[RndW-2:0], 1'b0};
         rem_ff <= (trial >= {1'b0, sum_ff}) ? SumW'(trial - {1'b0, sum_ff})
                                             : trial[SumW-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         if (op_ff == OP_DISPATCH) rd_ff <= ring_mem[pick][head_ff[pick]];
         else rd_ff <= ring_mem[disp_ff][head_ff[disp_ff]];
      end
      if (cmd.respond && op_ff == OP_ENQUEUE && lvl_ff != 2'd3 && next_id_ff < IdLimit
            && !count_ff[lvl_ff][RingAw]) begin
         ring_mem[lvl_ff][head_ff[lvl_ff] + count_ff[lvl_ff][RingAw-1:0]] <= IdW'(next_id_ff);
      end else if (cmd.respond && op_ff == OP_PREEMPT && has_disp_ff
            && count_ff[disp_ff] != '0) begin
         ring_mem[disp_ff][head_ff[disp_ff] + count_ff[disp_ff][RingAw-1:0]] <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
         next_id_ff <= '0;
         mask_ff <= '0;
         mask_valid_ff <= 1'b0;
         disp_ff <= '0;
         has_disp_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.respond;
         if (cmd.respond) begin
            rsp_status <= ST_OK;
            rsp_thread_id <= '0;
            rsp_chosen_level <= '0;
            unique case (op_ff)
               OP_ENQUEUE: begin
                  if (lvl_ff == 2'd3) rsp_status <= ST_BAD_LEVEL;
                  else if (next_id_ff >= IdLimit || count_ff[lvl_ff][RingAw])
                     rsp_status <= ST_FULL;
                  else begin
                     count_ff[lvl_ff] <= count_ff[lvl_ff] + 1'b1;
                     next_id_ff <= next_id_ff + 1'b1;
                     rsp_thread_id <= IdW'(next_id_ff);
                     rsp_chosen_level <= lvl_ff;
                  end
               end
               OP_DISPATCH: begin
                  if (live_mask == '0 || pick == 2'd3 || count_ff[pick] == '0)
                     rsp_status <= ST_NOT_READY;
                  if (live_mask != '0) begin
                     mask_ff <= use_mask_ff;
                     mask_valid_ff <= 1'b1;
                  end
                  if (live_mask != '0 && pick != 2'd3 && count_ff[pick] != '0) begin
                     disp_ff <= pick;
                     has_disp_ff <= 1'b1;
                     rsp_thread_id <= rd_ff;
                     rsp_chosen_level <= err_level;
                  end
               end
               default: begin
                  if (!has_disp_ff || count_ff[disp_ff] == '0) rsp_status <= ST_NO_DISPATCH;
                  else begin
                     has_disp_ff <= 1'b0;
                     head_ff[disp_ff] <= head_ff[disp_ff] + 1'b1;
                     if (op_ff == OP_FINISH) begin
                        count_ff[disp_ff] <= count_ff[disp_ff] - 1'b1;
                        mask_valid_ff <= 1'b0;
                     end
                     rsp_thread_id <= rd_ff;
                     rsp_chosen_level <= disp_ff;
                  end
               end
            endcase
         end
      end
   end
endmodule

@@ tb/tb_weighted_level_lottery_scheduler_top.sv @@
module tb_weighted_level_lottery_scheduler_top;
   import wlls_pkg::*;

   typedef struct {
      op_type op;
      logic [1:0] lvl;
      logic [RndW-1:0] rnd;
      bit hold;
   } sched_cmd_t;

   typedef struct {
      status_type st;
      logic [IdW-1:0] id;
      logic [1:0] lv;
   } sched_rsp_t;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_op;
   logic [1:0] req_prio_level;
   logic [RndW-1:0] req_random_value;
   logic csr_write;
   logic [CsrIdxW-1:0] csr_index;
   logic [WeightW-1:0] csr_wdata;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [IdW-1:0] rsp_thread_id;
   logic [1:0] rsp_chosen_level;

   weighted_level_lottery_scheduler_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_prio_level(req_prio_level),
      .req_random_value(req_random_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_thread_id(rsp_thread_id), .rsp_chosen_level(rsp_chosen_level)
   );

   sched_cmd_t pending_cmds[$];
   sched_rsp_t expected_rsps[$];
   int errors = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit quiet = 0;
   bit took = 0;

   logic [IdW-1:0] rings[3][RingDepth];
   logic [RingAw-1:0] heads[3];
   int counts[3];
   int next_id;
   logic [2:0] mask;
   bit mask_ok;
   int disp_lvl;
   bit disp_ok;
   int weights[3];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic sched_rsp_t schedule_step(op_type op, logic [1:0] lvl,
                                                logic [RndW-1:0] rnd);
      sched_rsp_t r;
      int sum;
      int ticket;
      int pick;
      int h;
      r.st = ST_OK;
      r.id = '0;
      r.lv = '0;
      case (op)
         OP_ENQUEUE: begin
            if (lvl > 2) r.st = ST_BAD_LEVEL;
            else if (next_id >= MaxThreadsDefault - 1 || counts[lvl] >= RingDepth)
               r.st = ST_FULL;
            else begin
               r.id = next_id[IdW-1:0];
               rings[lvl][heads[lvl] + counts[lvl][RingAw-1:0]] = r.id;
               counts[lvl]++;
               next_id++;
               r.lv = lvl;
            end
         end
         OP_DISPATCH: begin
            if (counts[0] == 0 && counts[1] == 0 && counts[2] == 0) r.st = ST_NOT_READY;
            else begin
               if (!mask_ok) begin
                  for (int i = 0; i < 3; i++) mask[i] = counts[i] != 0;
                  mask_ok = 1;
               end
               sum = 0;
               for (int i = 0; i < 3; i++) if (mask[i]) sum += weights[i];
               ticket = sum != 0 ? int'(rnd) % sum : 0;
               pick = 3;
               for (int i = 0; i < 3; i++)
                  if (pick == 3 && mask[i]) begin
                     if (ticket < weights[i]) pick = i;
                     else ticket -= weights[i];
                  end
               for (int i = 0; i < 3; i++) if (pick == 3 && mask[i]) pick = i;
               if (pick == 3 || counts[pick] == 0) r.st = ST_NOT_READY;
               else begin
                  disp_lvl = pick;
                  disp_ok = 1;
                  r.id = rings[pick][heads[pick]];
                  r.lv = pick[1:0];
               end
            end
         end
         default: begin
            if (!disp_ok || counts[disp_lvl] == 0) r.st = ST_NO_DISPATCH;
            else begin
               disp_ok = 0;
               h = heads[disp_lvl];
               r.id = rings[disp_lvl][h];
               r.lv = disp_lvl[1:0];
               if (op == OP_PREEMPT)
                  rings[disp_lvl][RingAw'(h + counts[disp_lvl])] = r.id;
               else begin
                  counts[disp_lvl]--;
                  mask_ok = 0;
               end
               heads[disp_lvl] = RingAw'(h + 1);
            end
         end
      endcase
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      sched_rsp_t e;
      if (!reset) begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("unexpected beat at %0t", $realtime);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.st) report("status", rsp_status, e.st);
               if (rsp_thread_id !== e.id) report("thread_id", rsp_thread_id, e.id);
               if (rsp_chosen_level !== e.lv) report("level", rsp_chosen_level, e.lv);
            end
         end
         if (start && !busy) begin
            expected_rsps.push_back(schedule_step(op_type'(req_op), req_prio_level,
                                                  req_random_value));
            took <= 1;
         end
         if (idle_cycles > 3000) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      sched_cmd_t c;
      logic nxt;
      nxt = start;
      if (took) begin
         void'(pending_cmds.pop_front());
         took <= 0;
         nxt = 0;
         if (!quiet && $urandom_range(3) == 0) gap_left = $urandom_range(1, 3);
      end
      if (!took || !nxt) begin
         if (gap_left > 0) begin
            gap_left--;
            nxt = 0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds[0];
            if (c.hold && expected_rsps.size() != 0) nxt = 0;
            else begin
               nxt = 1;
               req_op <= c.op;
               req_prio_level <= c.lvl;
               req_random_value <= c.rnd;
            end
         end else nxt = 0;
      end
      start <= nxt;
   end

   task automatic push(op_type op, logic [1:0] lvl, logic [RndW-1:0] rnd);
      sched_cmd_t c;
      c.op = op;
      c.lvl = lvl;
      c.rnd = rnd;
      c.hold = 0;
      pending_cmds.push_back(c);
   endtask

   task automatic push_random(int n);
      int k;
      int pick;
      k = 0;
      while (k < n) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            push(OP_ENQUEUE, 2'($urandom_range(2)), RndW'($urandom));
            k++;
         end else if (pick < 65) begin
            push(OP_DISPATCH, 2'($urandom_range(3)), RndW'($urandom));
            push(OP_PREEMPT, 2'($urandom_range(3)), RndW'($urandom));
            k += 2;
         end else if (pick < 85) begin
            push(OP_DISPATCH, 2'($urandom_range(3)), RndW'($urandom));
            push(OP_FINISH, 2'($urandom_range(3)), RndW'($urandom));
            k += 2;
         end else begin
            push(op_type'(2'($urandom_range(3))), 2'($urandom_range(3)),
                 RndW'($urandom));
            k++;
         end
      end
   endtask

   task automatic drain();
      wait (pending_cmds.size() == 0 && expected_rsps.size() == 0 && !took);
      @(negedge clock);
      wait (!start && !busy);
   endtask

   task automatic set_weights(int hw, int mw, int lw);
      logic [CsrIdxW-1:0] idx[3];
      int w[3];
      idx[0] = CsrHighWeight;
      idx[1] = CsrMiddleWeight;
      idx[2] = CsrLowWeight;
      w[0] = hw;
      w[1] = mw;
      w[2] = lw;
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_write <= 1;
         csr_index <= idx[i];
         csr_wdata <= WeightW'(w[i]);
         weights[i] = w[i];
      end
      @(negedge clock);
      csr_write <= 0;
   endtask

   initial begin
      sched_cmd_t c;
      reset = 1;
      start = 0;
      req_op = OP_ENQUEUE;
      req_prio_level = '0;
      req_random_value = '0;
      csr_write = 0;
      csr_index = CsrHighWeight;
      csr_wdata = '0;
      for (int i = 0; i < 3; i++) begin
         heads[i] = '0;
         counts[i] = 0;
      end
      next_id = 0;
      mask = '0;
      mask_ok = 0;
      disp_lvl = 0;
      disp_ok = 0;
      weights[0] = int'(HighWeightReset);
      weights[1] = int'(MiddleWeightReset);
      weights[2] = int'(LowWeightReset);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      push(OP_DISPATCH, 2'd0, '0);
      push(OP_PREEMPT, 2'd0, '0);
      push(OP_FINISH, 2'd3, '1);
      push(OP_ENQUEUE, 2'd3, '1);
      push(OP_ENQUEUE, 2'd2, '0);
      push(OP_DISPATCH, 2'd0, '1);
      push(OP_ENQUEUE, 2'd0, '0);
      push(OP_ENQUEUE, 2'd1, '0);
      push(OP_DISPATCH, 2'd0, '0);
      push(OP_FINISH, 2'd0, '0);
      push(OP_DISPATCH, 2'd3, '0);
      push(OP_DISPATCH, 2'd0, '1);
      push(OP_PREEMPT, 2'd0, '0);
      push(OP_PREEMPT, 2'd0, '0);
      push(OP_ENQUEUE, 2'd0, '0);
      push(OP_DISPATCH, 2'd0, 20'h55555);
      push(OP_FINISH, 2'd0, '0);
      push(OP_DISPATCH, 2'd0, 20'hAAAAA);
      push(OP_FINISH, 2'd0, '0);
      push(OP_FINISH, 2'd0, '0);
      drain();

      set_weights(15, 15, 15);
      push_random(300);
      drain();
      set_weights(1, 1, 1);
      push_random(300);
      c.op = OP_DISPATCH;
      c.lvl = '0;
      c.rnd = RndW'($urandom);
      c.hold = 1;
      pending_cmds.push_back(c);
      drain();
      set_weights(1, 15, 1);
      push_random(300);
      drain();
      set_weights(15, 1, 15);
      push_random(300);
      drain();
      set_weights($urandom_range(1, 15), $urandom_range(1, 15), $urandom_range(1, 15));
      push_random(500);
      drain();
      quiet = 1;
      set_weights(HighWeightReset, MiddleWeightReset, LowWeightReset);
      push_random(300);
      drain();
      repeat (30) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
